// ----- hw/rtl/stl_pkg.sv -----
// Shared types and constants for the source text lexer.
// No dependencies.
`default_nettype none
package stl_pkg;
	localparam int WORD_MAX = 32;
	localparam int LEN_W = $clog2(WORD_MAX + 1);
	localparam int IDX_W = $clog2(WORD_MAX);
	localparam int KW_COUNT = 12;
	localparam int QDEPTH = 4;
	localparam logic [30:0] VAL_MAX = 31'h7FFF_FFFF;

	typedef enum logic [2:0] {
		CLS_OP = 3'd0, CLS_SEP = 3'd1, CLS_KW = 3'd2, CLS_STR = 3'd3,
		CLS_INT = 3'd4, CLS_FLT = 3'd5, CLS_ID = 3'd6
	} cls_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       line_end;
	} in_t;

	typedef struct packed {
		logic [2:0]  token_class;
		logic [7:0]  lexeme_byte;
		logic        last;
		logic [3:0]  keyword_index;
		logic [30:0] int_value;
		logic        truncated;
	} out_t;

	// Command from front to back: emit buffered word, then optional single token.
	typedef struct packed {
		logic             word;
		logic [LEN_W-1:0] len;
		logic [2:0]       cls;
		logic [3:0]       kw;
		logic [30:0]      val;
		logic             trunc;
		logic             tok;
		logic             tok_op;
		logic [7:0]       tok_ch;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE, BK_WORD, BK_TOK
	} bk_state_t;

	function automatic logic [3:0] kw_len(input logic [3:0] k);
		case (k)
			4'd0: kw_len = 4'd3;  4'd1: kw_len = 4'd5;  4'd2: kw_len = 4'd9;
			4'd3: kw_len = 4'd7;  4'd4: kw_len = 4'd6;  4'd5: kw_len = 4'd9;
			4'd6: kw_len = 4'd5;  4'd7: kw_len = 4'd5;  4'd8: kw_len = 4'd6;
			4'd9: kw_len = 4'd3;  4'd10: kw_len = 4'd4; 4'd11: kw_len = 4'd5;
			default: kw_len = 4'd0;
		endcase
	endfunction

	function automatic logic [71:0] kw_text(input logic [3:0] k);
		case (k)
			4'd0: kw_text = {"nic", 48'h0};
			4'd1: kw_text = {"dycha", 32'h0};
			4'd2: kw_text = "przecinek";
			4'd3: kw_text = {"binarna", 16'h0};
			4'd4: kw_text = {"sta", 8'hC5, 8'h82, "a", 24'h0};
			4'd5: kw_text = {"przesta", 8'hC5, 8'h84};
			4'd6: kw_text = {"dalej", 32'h0};
			4'd7: kw_text = {"jesli", 32'h0};
			4'd8: kw_text = {"dopoki", 24'h0};
			4'd9: kw_text = {"dla", 48'h0};
			4'd10: kw_text = {"liga", 40'h0};
			4'd11: kw_text = {"zwroc", 32'h0};
			default: kw_text = 72'h0;
		endcase
	endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/source_text_lexer.sv -----
// Source text lexer top level: front classifier, command queue, back emitter.
// Depends on stl_pkg, stl_front, stl_queue, stl_back.
// A flushing input beat's command passes the command queue, back state and output register.
// Input takes one beat per cycle while the back is idle and the queue is empty; a queued
// word or token holds input (full) until the back has emitted it.
// Reset: asynchronous, clears all control state; buffer contents are not cleared.
`default_nettype none
module source_text_lexer (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               full,
	input  wire stl_pkg::in_t  in_data,
	output logic               empty,
	input  wire logic          pop,
	output stl_pkg::out_t      out_data
);
	logic q_full, q_push, q_empty, q_pop, busy, wr_en;
	stl_pkg::cmd_t wcmd, rcmd;
	logic [stl_pkg::IDX_W-1:0] wr_addr;
	logic [7:0] wr_data;

	stl_front u_front (
		.clk, .arst_n, .push, .full, .in_data, .q_full, .q_push, .q_cmd(wcmd),
		.busy, .wr_en, .wr_addr, .wr_data
	);
	stl_queue u_queue (
		.clk, .arst_n, .wr(q_push), .wdata(wcmd), .full(q_full),
		.rd(q_pop), .empty(q_empty), .rdata(rcmd)
	);
	stl_back u_back (
		.clk, .arst_n, .wr_en, .wr_addr, .wr_data, .q_empty, .q_cmd(rcmd),
		.q_pop, .busy, .empty, .pop, .out_data
	);
endmodule
`default_nettype wire

// ----- hw/rtl/stl_front.sv -----
// Front end: classifies bytes, builds word state, writes word bytes, issues commands.
// Depends on stl_pkg.
`default_nettype none
module stl_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	output logic                            full,
	input  wire stl_pkg::in_t               in_data,
	input  wire logic                       q_full,
	output logic                            q_push,
	output stl_pkg::cmd_t                   q_cmd,
	input  wire logic                       busy,
	output logic                            wr_en,
	output logic [stl_pkg::IDX_W-1:0]       wr_addr,
	output logic [7:0]                      wr_data
);
	logic [stl_pkg::LEN_W-1:0] len_q;
	logic skip_q, ovf_q, digits_q;
	logic [1:0] dots_q;
	logic [30:0] val_q;
	logic [stl_pkg::KW_COUNT-1:0] kwm_q;
	logic [7:0] first_q, last_q;

	logic [7:0] c;
	logic is_op, is_sep, is_skip, is_ws, flush, acc, app, fits;
	logic found;
	logic [3:0] kw;
	logic [2:0] cls;
	logic [34:0] nv;
	logic [3:0] d;

	assign c = in_data.ch;
	always_comb begin
		is_op = 1'b0;
		is_sep = 1'b0;
		case (c) inside
			"=", "+", "-", "*", "/", "&", "|", ">", "<": is_op = 1'b1;
			";", "[", "]", "{", "}", ":", "(", ")", ",": is_sep = 1'b1;
			default: ;
		endcase
	end
	assign is_skip = (c == "#") || (c == 8'h0A);
	assign is_ws = (c == " ") || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0D);

	// Back must have drained the word buffer before it is reused.
	assign full = q_full || busy;
	assign acc = push && !full;
	assign flush = in_data.line_end || (!skip_q && (is_skip || is_ws || is_op || is_sep));
	assign app = !in_data.line_end && !skip_q && !flush;
	assign fits = !ovf_q && (len_q < stl_pkg::LEN_W'(stl_pkg::WORD_MAX));

	always_comb begin
		found = 1'b0;
		kw = 4'd0;
		for (int k = stl_pkg::KW_COUNT - 1; k >= 0; k--) begin
			if (kwm_q[k] && !ovf_q && (stl_pkg::LEN_W'(stl_pkg::kw_len(4'(k))) == len_q)) begin
				found = 1'b1;
				kw = 4'(k);
			end
		end
		if (found) cls = stl_pkg::CLS_KW;
		else if ((len_q >= stl_pkg::LEN_W'(2) || ovf_q) && first_q == "\"" && last_q == "\"")
			cls = stl_pkg::CLS_STR;
		else if (digits_q && dots_q == 2'd0) cls = stl_pkg::CLS_INT;
		else if (digits_q && dots_q == 2'd1) cls = stl_pkg::CLS_FLT;
		else cls = stl_pkg::CLS_ID;
	end

	always_comb begin
		q_cmd.word = (len_q != '0);
		q_cmd.len = len_q;
		q_cmd.cls = cls;
		q_cmd.kw = found ? kw : 4'd0;
		q_cmd.val = (cls == stl_pkg::CLS_INT) ? val_q : 31'd0;
		q_cmd.trunc = ovf_q;
		q_cmd.tok = !in_data.line_end && !skip_q && (is_op || is_sep);
		q_cmd.tok_op = is_op;
		q_cmd.tok_ch = c;
	end
	assign q_push = acc && flush && (q_cmd.word || q_cmd.tok);

	assign wr_en = acc && app && fits;
	assign wr_addr = len_q[stl_pkg::IDX_W-1:0];
	assign wr_data = c;

	assign d = c[3:0];
	assign nv = val_q * 4'd10 + d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0; skip_q <= 1'b0; ovf_q <= 1'b0; digits_q <= 1'b1;
			dots_q <= 2'd0; val_q <= 31'd0; kwm_q <= '1; first_q <= 8'd0; last_q <= 8'd0;
		end else if (acc) begin
			if (in_data.line_end) skip_q <= 1'b0;
			else if (!skip_q && is_skip) skip_q <= 1'b1;
			if (flush) begin
				len_q <= '0; ovf_q <= 1'b0; digits_q <= 1'b1; dots_q <= 2'd0;
				val_q <= 31'd0; kwm_q <= '1; first_q <= 8'd0; last_q <= 8'd0;
			end else if (app) begin
				if (len_q == '0 && !ovf_q) first_q <= c;
				last_q <= c;
				if (fits) begin
					for (int k = 0; k < stl_pkg::KW_COUNT; k++) begin
						if (!((len_q < stl_pkg::LEN_W'(stl_pkg::kw_len(4'(k)))) &&
						      (stl_pkg::kw_text(4'(k)) >> (8 * (8 - 32'(len_q))) & 72'hFF)
						      == 72'(c)))
							kwm_q[k] <= 1'b0;
					end
					len_q <= len_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
					kwm_q <= '0;
				end
				if (c >= "0" && c <= "9") begin
					if (nv > 35'(stl_pkg::VAL_MAX)) val_q <= stl_pkg::VAL_MAX;
					else val_q <= nv[30:0];
				end else if (c == ".") begin
					if (dots_q != 2'd2) dots_q <= dots_q + 2'd1;
				end else begin
					digits_q <= 1'b0;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/stl_queue.sv -----
// Short command queue between front and back.
// Depends on stl_pkg.
`default_nettype none
module stl_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr,
	input  wire stl_pkg::cmd_t wdata,
	output logic               full,
	input  wire logic          rd,
	output logic               empty,
	output stl_pkg::cmd_t      rdata
);
	localparam int AW = $clog2(stl_pkg::QDEPTH);
	stl_pkg::cmd_t mem_q [stl_pkg::QDEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;

	assign full = (cnt_q == (AW+1)'(stl_pkg::QDEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !full) mem_q[wp_q] <= wdata;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr && !full) wp_q <= wp_q + 1'b1;
			if (rd && !empty) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr && !full) - (AW+1)'(rd && !empty);
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/stl_back.sv -----
// Back end: word buffer memory and byte emitter feeding a one-beat output register.
// Depends on stl_pkg.
`default_nettype none
module stl_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic [stl_pkg::IDX_W-1:0] wr_addr,
	input  wire logic [7:0]            wr_data,
	input  wire logic                  q_empty,
	input  wire stl_pkg::cmd_t         q_cmd,
	output logic                       q_pop,
	output logic                       busy,
	output logic                       empty,
	input  wire logic                  pop,
	output stl_pkg::out_t              out_data
);
	logic [7:0] buf_q [stl_pkg::WORD_MAX];
	stl_pkg::bk_state_t st_q, st_d;
	logic [stl_pkg::LEN_W-1:0] idx_q;
	logic [7:0] rd_q;
	logic ovld_q;
	stl_pkg::out_t o_q;
	logic slot, emit, lastb;
	logic [stl_pkg::LEN_W-1:0] ridx;

	assign slot = !ovld_q || pop;
	assign lastb = (idx_q + 1'b1 == q_cmd.len);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			stl_pkg::BK_IDLE:
				if (!q_empty) st_d = q_cmd.word ? stl_pkg::BK_WORD : stl_pkg::BK_TOK;
			stl_pkg::BK_WORD:
				if (slot && lastb) st_d = q_cmd.tok ? stl_pkg::BK_TOK : stl_pkg::BK_IDLE;
			stl_pkg::BK_TOK:
				if (slot) st_d = stl_pkg::BK_IDLE;
			default: st_d = stl_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		emit = 1'b0;
		q_pop = 1'b0;
		ridx = idx_q;
		unique case (st_q)
			stl_pkg::BK_IDLE: ridx = '0;
			stl_pkg::BK_WORD: begin
				emit = slot;
				q_pop = slot && lastb && !q_cmd.tok;
				ridx = slot ? idx_q + 1'b1 : idx_q;
			end
			stl_pkg::BK_TOK: begin
				emit = slot;
				q_pop = slot;
			end
			default: ;
		endcase
	end
	assign busy = (st_q != stl_pkg::BK_IDLE) || !q_empty;

	always_ff @(posedge clk) begin
		if (wr_en) buf_q[wr_addr] <= wr_data;
		rd_q <= buf_q[ridx[stl_pkg::IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= stl_pkg::BK_IDLE; idx_q <= '0; ovld_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == stl_pkg::BK_IDLE) idx_q <= '0;
			else if (st_q == stl_pkg::BK_WORD && slot) idx_q <= idx_q + 1'b1;
			if (emit) ovld_q <= 1'b1;
			else if (pop) ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (st_q == stl_pkg::BK_WORD) begin
				o_q.token_class <= q_cmd.cls;
				o_q.lexeme_byte <= rd_q;
				o_q.last <= lastb;
				o_q.keyword_index <= q_cmd.kw;
				o_q.int_value <= lastb ? q_cmd.val : 31'd0;
				o_q.truncated <= q_cmd.trunc;
			end else begin
				o_q.token_class <= q_cmd.tok_op ? stl_pkg::CLS_OP : stl_pkg::CLS_SEP;
				o_q.lexeme_byte <= q_cmd.tok_ch;
				o_q.last <= 1'b1;
				o_q.keyword_index <= 4'd0;
				o_q.int_value <= 31'd0;
				o_q.truncated <= 1'b0;
			end
		end
	end
	assign empty = !ovld_q;
	assign out_data = o_q;

	a_word_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == stl_pkg::BK_WORD) |-> (q_cmd.len != '0))
		else $error("word command with zero length");
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == stl_pkg::BK_WORD) |-> (idx_q < q_cmd.len))
		else $error("index past word length");
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != stl_pkg::BK_IDLE) |-> !wr_en)
		else $error("buffer written while draining");
endmodule
`default_nettype wire
